[src/icm_pkg.sv]
package icm_pkg;

  localparam int MemWords  = 4096;
  localparam int FifoDepth = 16;
  localparam int MemAw     = $clog2(MemWords);
  localparam int PcW       = MemAw + 1;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoSw    = FifoAw + 1;
  localparam int FifoCw    = $clog2(FifoDepth + 1);
  localparam int AddrW     = 12;
  localparam int WordW     = 64;
  localparam int RbW       = 32;

  localparam logic [WordW-1:0] HaltWord  = 64'd99;
  localparam logic [WordW-1:0] InstrLimit = 64'd100000;

  localparam logic [6:0] OpAdd = 7'd1;
  localparam logic [6:0] OpMul = 7'd2;
  localparam logic [6:0] OpIn  = 7'd3;
  localparam logic [6:0] OpOut = 7'd4;
  localparam logic [6:0] OpJnz = 7'd5;
  localparam logic [6:0] OpJz  = 7'd6;
  localparam logic [6:0] OpLt  = 7'd7;
  localparam logic [6:0] OpEq  = 7'd8;
  localparam logic [6:0] OpRel = 7'd9;

  localparam logic [3:0] ModePos = 4'd0;
  localparam logic [3:0] ModeImm = 4'd1;
  localparam logic [3:0] ModeRel = 4'd2;

  typedef enum logic [1:0] {
    KindLoad,
    KindPush,
    KindExec,
    KindRead
  } kind_e;

  typedef enum logic [2:0] {
    StatDone,
    StatBlocked,
    StatHalted,
    StatFault,
    StatFull
  } status_e;

  typedef enum logic [4:0] {
    StClear,
    StIdle,
    StDisp,
    StRdWait,
    StDec0,
    StDec1,
    StDec2,
    StOpnd,
    StOpWait,
    StLdA,
    StLdB,
    StExec,
    StMul0,
    StMul1,
    StMul2,
    StResp
  } st_e;

  typedef struct packed {
    kind_e                    kind;
    logic [AddrW-1:0]         address;
    logic signed [WordW-1:0]  value;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic                     out_valid;
    logic signed [WordW-1:0]  out_value;
    logic signed [WordW-1:0]  read_data;
    logic [AddrW-1:0]         program_counter;
  } out_t;

  function automatic logic [1:0] operand_count(logic [6:0] op);
    logic [1:0] n;
    case (op)
      OpAdd, OpMul, OpLt, OpEq: n = 2'd3;
      OpJnz, OpJz:              n = 2'd2;
      OpIn, OpOut, OpRel:       n = 2'd1;
      default:                  n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

[src/intcode_machine_step_core.sv]
// A load or push beat passes from dispatch to the response state, a read adds a read-wait state.
// An execute beat runs through dispatch, the decode states Dec0, Dec1 and Dec2, one or two operand states
// per operand, a closing operand state, the operand loads LdA and LdB and the execute state; a multiply adds
// Mul0, Mul1 and Mul2 on the shared 32x32 unit, a halt ends after Dec0 and a fault ends the beat early.
// One beat at a time: ready returns when the result is registered, later if the result register is still full.
// After reset the word store is cleared in a sweep over all 4096 words with ready held low.
module intcode_machine_step_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  icm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output icm_pkg::out_t  out_data_o
);

  icm_pkg::st_e state_q, state_d;

  logic [icm_pkg::MemAw:0]     clr_q, clr_d;
  logic [icm_pkg::WordW-1:0]   mem [icm_pkg::MemWords];
  logic [icm_pkg::WordW-1:0]   rdata_q;
  logic                        mem_we;
  logic [icm_pkg::MemAw-1:0]   mem_addr;
  logic [icm_pkg::WordW-1:0]   mem_wdata;

  logic [icm_pkg::WordW-1:0]   fifo_mem [icm_pkg::FifoDepth];
  logic [icm_pkg::WordW-1:0]   fifo_rd_q;
  logic                        fifo_push;
  logic [icm_pkg::FifoAw-1:0]  fifo_tail;
  logic [icm_pkg::FifoSw-1:0]  tail_sum;
  logic [icm_pkg::FifoAw-1:0]  head_q, head_d, head_inc;
  logic [icm_pkg::FifoCw-1:0]  cnt_q, cnt_d;

  icm_pkg::in_t                item_q, item_d;
  logic [icm_pkg::PcW-1:0]     pc_q, pc_d;
  logic [icm_pkg::RbW-1:0]     rb_q, rb_d;
  logic                        fault_q, fault_d;

  logic [16:0]                 iw_q, iw_d;
  logic [9:0]                  q_q, q_d;
  logic [6:0]                  t_q, t_d;
  logic [6:0]                  op_q, op_d;
  logic [1:0]                  mode_q [3];
  logic [1:0]                  mode_d [3];
  logic [1:0]                  idx_q, idx_d;
  logic [icm_pkg::MemAw-1:0]   addr_q [3];
  logic [icm_pkg::MemAw-1:0]   addr_d [3];
  logic [icm_pkg::WordW-1:0]   a_q, a_d, b_q, b_d, acc_q, acc_d;

  icm_pkg::status_e            pst_q, pst_d;
  logic                        pov_q, pov_d;
  logic [icm_pkg::WordW-1:0]   poutv_q, poutv_d, prd_q, prd_d;
  icm_pkg::out_t               res_q, res_d;
  logic                        res_valid_q, res_valid_d;

  logic [31:0]                 mul_x, mul_y;
  logic [63:0]                 mul_p;

  logic [29:0]                 q_prod;
  logic [16:0]                 op_full;
  logic [17:0]                 t_prod;
  logic [14:0]                 u_prod;
  logic [3:0]                  m1, m2, m3;
  logic [1:0]                  n_ops;
  logic [icm_pkg::PcW-1:0]     slot;
  logic [1:0]                  cur_mode;
  logic [64:0]                 eff_sum;

  logic addr_bad, pc_bad, halt0, bad0, bad2, opnd_done, slot_bad, opw_bad;
  logic take, jfault, fifo_empty, fifo_full, res_free;

  assign mul_p = mul_x * mul_y;

  assign q_prod  = 30'(rdata_q[16:0]) * 30'd5243;
  assign op_full = iw_q - 17'(q_q * 17'd100);
  assign t_prod  = 18'(q_q) * 18'd205;
  assign u_prod  = 15'(t_q) * 15'd205;
  assign m3      = u_prod[14:11];
  assign m1      = 4'(q_q - 10'(t_q * 10'd10));
  assign m2      = 4'(t_q - 7'(m3 * 7'd10));
  assign n_ops   = icm_pkg::operand_count(op_q);

  assign addr_bad  = int'(item_q.address) >= icm_pkg::MemWords;
  assign pc_bad    = int'(pc_q) >= icm_pkg::MemWords;
  assign halt0     = rdata_q == icm_pkg::HaltWord;
  assign bad0      = rdata_q[63] || (rdata_q >= icm_pkg::InstrLimit);
  assign bad2      = (op_q < icm_pkg::OpAdd) || (op_q > icm_pkg::OpRel) || (m1 > icm_pkg::ModeRel)
                  || (n_ops >= 2'd2 && m2 > icm_pkg::ModeRel)
                  || (n_ops == 2'd3 && m3 > icm_pkg::ModeRel)
                  || (n_ops < 2'd3 && m3 != 4'd0) || (n_ops < 2'd2 && m2 != 4'd0)
                  || (n_ops == 2'd3 && m3 == icm_pkg::ModeImm)
                  || (op_q == icm_pkg::OpIn && m1 == icm_pkg::ModeImm);
  assign opnd_done = idx_q == n_ops;
  assign slot      = pc_q + icm_pkg::PcW'(idx_q) + icm_pkg::PcW'(1);
  assign slot_bad  = int'(slot) >= icm_pkg::MemWords;
  assign eff_sum   = {rdata_q[63], rdata_q}
                   + ((cur_mode == 2'(icm_pkg::ModeRel)) ? {{33{rb_q[31]}}, rb_q} : 65'd0);
  assign opw_bad   = eff_sum[64] || (eff_sum[63:0] >= 64'(icm_pkg::MemWords));
  assign take      = (op_q == icm_pkg::OpJnz) ? (a_q != '0) : (a_q == '0);
  assign jfault    = take && (rdata_q >= 64'(icm_pkg::MemWords));
  assign fifo_empty = cnt_q == '0;
  assign fifo_full  = cnt_q == icm_pkg::FifoCw'(icm_pkg::FifoDepth);
  assign res_free   = !res_valid_q || out_ready_i;

  assign tail_sum  = icm_pkg::FifoSw'(head_q) + icm_pkg::FifoSw'(cnt_q);
  assign fifo_tail = (int'(tail_sum) >= icm_pkg::FifoDepth)
                   ? icm_pkg::FifoAw'(tail_sum - icm_pkg::FifoSw'(icm_pkg::FifoDepth))
                   : icm_pkg::FifoAw'(tail_sum);
  assign head_inc  = (int'(head_q) == icm_pkg::FifoDepth - 1) ? '0 : head_q + 1'b1;

  always_comb begin
    case (idx_q)
      2'd0:    cur_mode = mode_q[0];
      2'd1:    cur_mode = mode_q[1];
      default: cur_mode = mode_q[2];
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      icm_pkg::StClear: begin
        if (int'(clr_q) == icm_pkg::MemWords - 1) state_d = icm_pkg::StIdle;
      end
      icm_pkg::StIdle: begin
        if (in_valid_i) state_d = icm_pkg::StDisp;
      end
      icm_pkg::StDisp: begin
        case (item_q.kind)
          icm_pkg::KindRead: state_d = addr_bad ? icm_pkg::StResp : icm_pkg::StRdWait;
          icm_pkg::KindExec: state_d = (fault_q || pc_bad) ? icm_pkg::StResp : icm_pkg::StDec0;
          default:           state_d = icm_pkg::StResp;
        endcase
      end
      icm_pkg::StRdWait: state_d = icm_pkg::StResp;
      icm_pkg::StDec0:   state_d = (halt0 || bad0) ? icm_pkg::StResp : icm_pkg::StDec1;
      icm_pkg::StDec1:   state_d = icm_pkg::StDec2;
      icm_pkg::StDec2:   state_d = bad2 ? icm_pkg::StResp : icm_pkg::StOpnd;
      icm_pkg::StOpnd: begin
        if (opnd_done) state_d = icm_pkg::StLdA;
        else if (slot_bad) state_d = icm_pkg::StResp;
        else if (cur_mode != 2'(icm_pkg::ModeImm)) state_d = icm_pkg::StOpWait;
      end
      icm_pkg::StOpWait: state_d = opw_bad ? icm_pkg::StResp : icm_pkg::StOpnd;
      icm_pkg::StLdA:    state_d = icm_pkg::StLdB;
      icm_pkg::StLdB:    state_d = icm_pkg::StExec;
      icm_pkg::StExec:   state_d = (op_q == icm_pkg::OpMul) ? icm_pkg::StMul0 : icm_pkg::StResp;
      icm_pkg::StMul0:   state_d = icm_pkg::StMul1;
      icm_pkg::StMul1:   state_d = icm_pkg::StMul2;
      icm_pkg::StMul2:   state_d = icm_pkg::StResp;
      icm_pkg::StResp: begin
        if (res_free) state_d = icm_pkg::StIdle;
      end
      default: state_d = icm_pkg::StIdle;
    endcase
  end

  always_comb begin
    clr_d = clr_q;
    item_d = item_q;
    pc_d = pc_q;
    rb_d = rb_q;
    fault_d = fault_q;
    head_d = head_q;
    cnt_d = cnt_q;
    iw_d = iw_q;
    q_d = q_q;
    t_d = t_q;
    op_d = op_q;
    mode_d = mode_q;
    idx_d = idx_q;
    addr_d = addr_q;
    a_d = a_q;
    b_d = b_q;
    acc_d = acc_q;
    pst_d = pst_q;
    pov_d = pov_q;
    poutv_d = poutv_q;
    prd_d = prd_q;
    res_d = res_q;
    res_valid_d = res_valid_q && !out_ready_i;
    mem_we = 1'b0;
    mem_addr = '0;
    mem_wdata = '0;
    fifo_push = 1'b0;
    mul_x = '0;
    mul_y = '0;
    case (state_q)
      icm_pkg::StClear: begin
        mem_we = 1'b1;
        mem_addr = clr_q[icm_pkg::MemAw-1:0];
        clr_d = clr_q + 1'b1;
      end
      icm_pkg::StIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          pst_d = icm_pkg::StatDone;
          pov_d = 1'b0;
          poutv_d = '0;
          prd_d = '0;
        end
      end
      icm_pkg::StDisp: begin
        case (item_q.kind)
          icm_pkg::KindLoad: begin
            if (addr_bad) begin
              pst_d = icm_pkg::StatFault;
            end else begin
              mem_we = 1'b1;
              mem_addr = icm_pkg::MemAw'(item_q.address);
              mem_wdata = item_q.value;
            end
          end
          icm_pkg::KindPush: begin
            if (fifo_full) begin
              pst_d = icm_pkg::StatFull;
            end else begin
              fifo_push = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end
          end
          icm_pkg::KindRead: begin
            if (addr_bad) pst_d = icm_pkg::StatFault;
            mem_addr = icm_pkg::MemAw'(item_q.address);
          end
          default: begin
            if (fault_q || pc_bad) begin
              pst_d = icm_pkg::StatFault;
              fault_d = 1'b1;
            end
            mem_addr = icm_pkg::MemAw'(pc_q);
          end
        endcase
      end
      icm_pkg::StRdWait: prd_d = rdata_q;
      icm_pkg::StDec0: begin
        if (halt0) begin
          pst_d = icm_pkg::StatHalted;
        end else if (bad0) begin
          pst_d = icm_pkg::StatFault;
          fault_d = 1'b1;
        end
        iw_d = rdata_q[16:0];
        q_d = q_prod[28:19];
      end
      icm_pkg::StDec1: begin
        op_d = op_full[6:0];
        t_d = t_prod[17:11];
      end
      icm_pkg::StDec2: begin
        if (bad2) begin
          pst_d = icm_pkg::StatFault;
          fault_d = 1'b1;
        end
        mode_d[0] = m1[1:0];
        mode_d[1] = m2[1:0];
        mode_d[2] = m3[1:0];
        idx_d = '0;
      end
      icm_pkg::StOpnd: begin
        if (!opnd_done) begin
          if (slot_bad) begin
            pst_d = icm_pkg::StatFault;
            fault_d = 1'b1;
          end else if (cur_mode == 2'(icm_pkg::ModeImm)) begin
            case (idx_q)
              2'd0:    addr_d[0] = icm_pkg::MemAw'(slot);
              2'd1:    addr_d[1] = icm_pkg::MemAw'(slot);
              default: addr_d[2] = icm_pkg::MemAw'(slot);
            endcase
            idx_d = idx_q + 1'b1;
          end
          mem_addr = icm_pkg::MemAw'(slot);
        end
      end
      icm_pkg::StOpWait: begin
        if (opw_bad) begin
          pst_d = icm_pkg::StatFault;
          fault_d = 1'b1;
        end
        case (idx_q)
          2'd0:    addr_d[0] = icm_pkg::MemAw'(eff_sum);
          2'd1:    addr_d[1] = icm_pkg::MemAw'(eff_sum);
          default: addr_d[2] = icm_pkg::MemAw'(eff_sum);
        endcase
        idx_d = idx_q + 1'b1;
      end
      icm_pkg::StLdA: mem_addr = addr_q[0];
      icm_pkg::StLdB: begin
        a_d = rdata_q;
        mem_addr = addr_q[1];
      end
      icm_pkg::StExec: begin
        b_d = rdata_q;
        case (op_q)
          icm_pkg::OpAdd: begin
            mem_we = 1'b1;
            mem_addr = addr_q[2];
            mem_wdata = a_q + rdata_q;
            pc_d = pc_q + icm_pkg::PcW'(4);
          end
          icm_pkg::OpIn: begin
            if (fifo_empty) begin
              pst_d = icm_pkg::StatBlocked;
            end else begin
              mem_we = 1'b1;
              mem_addr = addr_q[0];
              mem_wdata = fifo_rd_q;
              head_d = head_inc;
              cnt_d = cnt_q - 1'b1;
              pc_d = pc_q + icm_pkg::PcW'(2);
            end
          end
          icm_pkg::OpOut: begin
            pov_d = 1'b1;
            poutv_d = a_q;
            pc_d = pc_q + icm_pkg::PcW'(2);
          end
          icm_pkg::OpJnz, icm_pkg::OpJz: begin
            if (jfault) begin
              pst_d = icm_pkg::StatFault;
              fault_d = 1'b1;
            end else if (take) begin
              pc_d = icm_pkg::PcW'(rdata_q);
            end else begin
              pc_d = pc_q + icm_pkg::PcW'(3);
            end
          end
          icm_pkg::OpLt: begin
            mem_we = 1'b1;
            mem_addr = addr_q[2];
            mem_wdata = {63'b0, $signed(a_q) < $signed(rdata_q)};
            pc_d = pc_q + icm_pkg::PcW'(4);
          end
          icm_pkg::OpEq: begin
            mem_we = 1'b1;
            mem_addr = addr_q[2];
            mem_wdata = {63'b0, a_q == rdata_q};
            pc_d = pc_q + icm_pkg::PcW'(4);
          end
          icm_pkg::OpRel: begin
            rb_d = rb_q + a_q[31:0];
            pc_d = pc_q + icm_pkg::PcW'(2);
          end
          default: ;
        endcase
      end
      icm_pkg::StMul0: begin
        mul_x = a_q[31:0];
        mul_y = b_q[31:0];
        acc_d = mul_p;
      end
      icm_pkg::StMul1: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
        acc_d = acc_q + {mul_p[31:0], 32'b0};
      end
      icm_pkg::StMul2: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
        mem_we = 1'b1;
        mem_addr = addr_q[2];
        mem_wdata = acc_q + {mul_p[31:0], 32'b0};
        pc_d = pc_q + icm_pkg::PcW'(4);
      end
      icm_pkg::StResp: begin
        if (res_free) begin
          res_valid_d = 1'b1;
          res_d.status = pst_q;
          res_d.out_valid = pov_q;
          res_d.out_value = poutv_q;
          res_d.read_data = prd_q;
          res_d.program_counter = pc_q[icm_pkg::AddrW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) fifo_mem[fifo_tail] <= item_q.value;
    fifo_rd_q <= fifo_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    iw_q <= iw_d;
    q_q <= q_d;
    t_q <= t_d;
    op_q <= op_d;
    mode_q <= mode_d;
    idx_q <= idx_d;
    addr_q <= addr_d;
    a_q <= a_d;
    b_q <= b_d;
    acc_q <= acc_d;
    pst_q <= pst_d;
    pov_q <= pov_d;
    poutv_q <= poutv_d;
    prd_q <= prd_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icm_pkg::StClear;
      clr_q <= '0;
      pc_q <= '0;
      rb_q <= '0;
      fault_q <= 1'b0;
      head_q <= '0;
      cnt_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      pc_q <= pc_d;
      rb_q <= rb_d;
      fault_q <= fault_d;
      head_q <= head_d;
      cnt_q <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign in_ready_o  = state_q == icm_pkg::StIdle;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fault_q |=> fault_q)
    else $error("Sticky fault flag cleared.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= icm_pkg::FifoDepth)
    else $error("Input FIFO count above depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == icm_pkg::StIdle || state_q == icm_pkg::StResp) |-> !mem_we)
    else $error("Word store written outside an item.");

endmodule

[test/tb_intcode_machine_step_core.sv]
`timescale 1ns / 1ps

module tb_intcode_machine_step_core;

  localparam int WatchLimit = 20000;

  class step_scoreboard;
    logic [63:0] words [icm_pkg::MemWords];
    logic [63:0] pending_inputs [$];
    int unsigned ip;
    logic [31:0] rel_base;
    bit faulted;
    icm_pkg::out_t expected_q [$];
    int mismatches;

    function void clear();
      foreach (words[i]) words[i] = '0;
      pending_inputs.delete();
      ip = 0;
      rel_base = '0;
      faulted = 0;
      expected_q.delete();
      mismatches = 0;
    endfunction

    function bit locate(int unsigned pc, int unsigned idx, logic [3:0] mode,
                        output int unsigned loc);
      longint unsigned slot;
      longint w;
      longint base;
      slot = pc + idx;
      loc = 0;
      if (slot >= icm_pkg::MemWords) return 0;
      if (mode == icm_pkg::ModeImm) begin
        loc = int'(slot);
        return 1;
      end
      w = words[slot];
      base = (mode == icm_pkg::ModeRel) ? longint'(signed'(rel_base)) : 0;
      if (w < -base || w >= icm_pkg::MemWords - base) return 0;
      loc = int'(w + base);
      return 1;
    endfunction

    function icm_pkg::status_e run_one(output logic [63:0] emitted, output bit emits);
      logic [63:0] iw, digits, a, b;
      logic [6:0] op;
      logic [3:0] mode [4];
      int unsigned loc [4];
      int unsigned n, pc;
      bit take;
      emitted = '0;
      emits = 0;
      pc = ip;
      if (faulted) return icm_pkg::StatFault;
      if (pc >= icm_pkg::MemWords) begin
        faulted = 1;
        return icm_pkg::StatFault;
      end
      iw = words[pc];
      if (iw == icm_pkg::HaltWord) return icm_pkg::StatHalted;
      if (iw[63]) begin
        faulted = 1;
        return icm_pkg::StatFault;
      end
      op = iw % 100;
      digits = iw / 100;
      if (op < icm_pkg::OpAdd || op > icm_pkg::OpRel) begin
        faulted = 1;
        return icm_pkg::StatFault;
      end
      n = icm_pkg::operand_count(op);
      for (int i = 0; i < 4; i++) begin
        mode[i] = icm_pkg::ModePos;
        loc[i] = 0;
      end
      for (int i = 1; i <= n; i++) begin
        mode[i] = digits % 10;
        digits = digits / 10;
        if (mode[i] > icm_pkg::ModeRel || !locate(pc, i, mode[i], loc[i])) begin
          faulted = 1;
          return icm_pkg::StatFault;
        end
      end
      if (digits != 0 || (n == 3 && mode[3] == icm_pkg::ModeImm) ||
          (op == icm_pkg::OpIn && mode[1] == icm_pkg::ModeImm)) begin
        faulted = 1;
        return icm_pkg::StatFault;
      end
      a = words[loc[1]];
      b = (n >= 2) ? words[loc[2]] : '0;
      case (op)
        icm_pkg::OpAdd: begin words[loc[3]] = a + b; ip = pc + 4; end
        icm_pkg::OpMul: begin words[loc[3]] = a * b; ip = pc + 4; end
        icm_pkg::OpIn: begin
          if (pending_inputs.size() == 0) return icm_pkg::StatBlocked;
          words[loc[1]] = pending_inputs.pop_front();
          ip = pc + 2;
        end
        icm_pkg::OpOut: begin emitted = a; emits = 1; ip = pc + 2; end
        icm_pkg::OpJnz, icm_pkg::OpJz: begin
          take = (op == icm_pkg::OpJnz) ? (a != 0) : (a == 0);
          if (take) begin
            if (b >= icm_pkg::MemWords) begin
              faulted = 1;
              return icm_pkg::StatFault;
            end
            ip = b;
          end else begin
            ip = pc + 3;
          end
        end
        icm_pkg::OpLt: begin
          words[loc[3]] = (signed'(a) < signed'(b)) ? 1 : 0;
          ip = pc + 4;
        end
        icm_pkg::OpEq: begin words[loc[3]] = (a == b) ? 1 : 0; ip = pc + 4; end
        default: begin rel_base = rel_base + a[31:0]; ip = pc + 2; end
      endcase
      return icm_pkg::StatDone;
    endfunction

    function void note_beat(icm_pkg::in_t beat);
      icm_pkg::out_t r;
      logic [63:0] emitted;
      bit emits;
      r = '0;
      r.status = icm_pkg::StatDone;
      case (beat.kind)
        icm_pkg::KindLoad: words[beat.address] = beat.value;
        icm_pkg::KindRead: r.read_data = words[beat.address];
        icm_pkg::KindPush: begin
          if (pending_inputs.size() >= icm_pkg::FifoDepth) r.status = icm_pkg::StatFull;
          else pending_inputs = {pending_inputs, beat.value};
        end
        default: begin
          r.status = run_one(emitted, emits);
          r.out_valid = emits;
          r.out_value = emitted;
        end
      endcase
      r.program_counter = ip[icm_pkg::AddrW-1:0];
      expected_q = {expected_q, r};
    endfunction

    function void check_result(icm_pkg::out_t got);
      icm_pkg::out_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.out_valid !== e.out_valid ||
          got.out_value !== e.out_value || got.read_data !== e.read_data ||
          got.program_counter !== e.program_counter) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, actual %p", e, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  icm_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  icm_pkg::out_t out_data_o;

  step_scoreboard sb;
  bit stimulus_done = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  intcode_machine_step_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  task automatic send_beat(icm_pkg::kind_e k, int unsigned addr, logic [63:0] val);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= '{kind: k, address: addr[icm_pkg::AddrW-1:0], value: val};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(in_data_i);
  endtask

  task automatic load_word(int unsigned addr, logic [63:0] val);
    send_beat(icm_pkg::KindLoad, addr, val);
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: w = $urandom_range(0, 20);
      1: w = -longint'($urandom_range(1, 20));
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] rand_instr();
    int op;
    longint m;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 99999);
    op = $urandom_range(1, 9);
    m = 0;
    for (int i = 0; i < 3; i++) m = m * 10 + $urandom_range(0, 2);
    if (icm_pkg::operand_count(op) == 3 && $urandom_range(0, 3) != 0 && m >= 100) m = m % 100;
    if (icm_pkg::operand_count(op) != 3)
      m = m % ((icm_pkg::operand_count(op) == 2) ? 100 : 10);
    return m * 100 + op;
  endfunction

  // A program lives in the low words and its data in words 20 to 40, so
  // position and relative operands mostly land in range.
  task automatic random_program();
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 2) == 0) load_word(i, rand_instr());
      else if ($urandom_range(0, 3) == 0) load_word(i, $urandom_range(0, 50));
      else load_word(i, rand_instr() % 100 == 0 ? 1 : $urandom_range(20, 40));
    end
    for (int i = 0; i < 4; i++) load_word($urandom_range(20, 40), rand_word());
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: add, multiply, input, output, a jump and a relative operand mode.
    load_word(0, 1101); load_word(1, 7); load_word(2, -3); load_word(3, 100);
    load_word(4, 1002); load_word(5, 100); load_word(6, -5); load_word(7, 101);
    load_word(8, 203); load_word(9, 100);
    load_word(10, 4); load_word(11, 101);
    load_word(12, 1105); load_word(13, 0); load_word(14, 0);
    send_beat(icm_pkg::KindExec, 0, 0);
    send_beat(icm_pkg::KindExec, 0, 0);
    send_beat(icm_pkg::KindExec, 0, 0);
    send_beat(icm_pkg::KindPush, 0, 64'h8000_0000_0000_0000);
    send_beat(icm_pkg::KindExec, 0, 0);
    send_beat(icm_pkg::KindExec, 0, 0);
    send_beat(icm_pkg::KindExec, 0, 0);
    send_beat(icm_pkg::KindRead, 4095, 0);
    send_beat(icm_pkg::KindLoad, 4095, 64'h7fff_ffff_ffff_ffff);
    send_beat(icm_pkg::KindRead, 101, 0);
    for (int i = 0; i < 18; i++) send_beat(icm_pkg::KindPush, 0, {$urandom, $urandom});

    // Random programs; reset is never reasserted, so fault is sticky and
    // later phases exercise loads, reads and pushes as well.
    for (int it = 0; it < 900; ) begin
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        random_program();
        it += 20;
      end else if (sel < 60) begin
        send_beat(icm_pkg::KindExec, 0, 0);
        it++;
      end else if (sel < 72) begin
        send_beat(icm_pkg::KindPush, 0, rand_word());
        it++;
      end else if (sel < 86) begin
        send_beat(icm_pkg::KindRead, $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) :
                  $urandom_range(0, 40), 0);
        it++;
      end else begin
        send_beat(icm_pkg::KindLoad, $urandom_range(0, 40), rand_instr());
        it++;
      end
      if (it > 450 && it < 480) begin
        hold_off = 1;
        for (int j = 0; j < 12; j++) send_beat(icm_pkg::KindRead, $urandom_range(0, 4095), 0);
        it += 30;
      end
    end
    in_valid_i <= 0;
    stimulus_done = 1;
  end

  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
          out_ready_i <= 0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cycles > WatchLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (stimulus_done && sb.expected_q.size() == 0) begin
        repeat (40) @(posedge clk_i);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
          $display("SCOREBOARD CLEAN");
        end else begin
          $display("SCOREBOARD MISMATCH");
        end
        $finish;
      end
    end
  end

endmodule
